// ===== hdl/icfm_pkg.sv =====
// Shared constants and types for the input capture frequency meter.
// No dependencies; imported by every module of the block.
package icfm_pkg;

   localparam int WINDOW_CAPTURES = 10;
   localparam int CAP_W           = 32;
   localparam int SUM_W           = 36;
   localparam int COUNT_W         = $clog2(WINDOW_CAPTURES);
   localparam int STEP_W          = $clog2(SUM_W);
   localparam int AVG_DIVISOR     = WINDOW_CAPTURES - 1;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMER_CLOCK = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTO_RELOAD = 1'b1;

   localparam logic [CAP_W-1:0] AUTO_RELOAD_RESET = 32'd65535;

   typedef struct packed {
      logic start;
      logic first;
      logic seed;
   } acc_cmd_type;

   typedef struct packed {
      logic busy;
      logic done;
   } unit_status_type;

endpackage

// ===== hdl/icfm_accum.sv =====
// Bit-serial period and window statistics unit: difference, wrap, min, max, sum.
// Depends on icfm_pkg.
module icfm_accum
   import icfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  acc_cmd_type       cmd,
   input  logic [CAP_W-1:0]  capture,
   input  logic [CAP_W-1:0]  auto_reload,
   output unit_status_type   status,
   output logic [CAP_W-1:0]  shortest,
   output logic [CAP_W-1:0]  longest,
   output logic [SUM_W-1:0]  period_sum
);

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_DIFF = 2'd1;
   localparam logic [1:0] PH_STAT = 2'd2;

   logic [1:0]        phase_ff;
   logic [STEP_W-1:0] step_ff;
   logic              done_ff;
   logic [CAP_W-1:0]  cap_ff, prev_ff, arr_ff, per_ff, wrap_ff, min_ff, max_ff;
   logic [SUM_W-1:0]  sum_ff;
   logic              borrow_ff, carry_ff, nz_ff, seed_ff, lt_ff, gt_ff, sc_ff;

   logic              n_b, p_b, a_b, d_b, w_b, pb, s_b, in_range;
   logic              borrow_in, carry_in, nz_in, sc_in, lt_in, gt_in;
   logic [CAP_W-1:0]  diff_shift, wrap_shift;

   always_comb begin
      n_b        = cap_ff[0];
      p_b        = prev_ff[0];
      a_b        = arr_ff[0];
      // next - prev, one bit per cycle
      d_b        = n_b ^ p_b ^ borrow_ff;
      borrow_in  = (~n_b & p_b) | (~(n_b ^ p_b) & borrow_ff);
      // wrapped period equals auto_reload + (next - prev) + 1
      w_b        = a_b ^ d_b ^ carry_ff;
      carry_in   = (a_b & d_b) | (a_b & carry_ff) | (d_b & carry_ff);
      nz_in      = nz_ff | d_b;
      diff_shift = {d_b, per_ff[CAP_W-1:1]};
      wrap_shift = {w_b, wrap_ff[CAP_W-1:1]};

      in_range   = step_ff < STEP_W'(CAP_W);
      pb         = per_ff[0] & in_range;
      s_b        = pb ^ sum_ff[0] ^ sc_ff;
      sc_in      = (pb & sum_ff[0]) | (pb & sc_ff) | (sum_ff[0] & sc_ff);
      // LSB-first compare: the highest differing bit decides
      lt_in      = (in_range && (pb != min_ff[0])) ? min_ff[0] : lt_ff;
      gt_in      = (in_range && (pb != max_ff[0])) ? pb : gt_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         case (phase_ff)
            PH_IDLE: begin
               if (cmd.start) begin
                  if (cmd.first) begin
                     prev_ff <= capture;
                     sum_ff  <= '0;
                  end else begin
                     phase_ff  <= PH_DIFF;
                     step_ff   <= '0;
                     cap_ff    <= capture;
                     arr_ff    <= auto_reload;
                     borrow_ff <= 1'b0;
                     carry_ff  <= 1'b1;
                     nz_ff     <= 1'b0;
                     seed_ff   <= cmd.seed;
                  end
               end
            end
            PH_DIFF: begin
               borrow_ff <= borrow_in;
               carry_ff  <= carry_in;
               nz_ff     <= nz_in;
               wrap_ff   <= wrap_shift;
               cap_ff    <= {1'b0, cap_ff[CAP_W-1:1]};
               arr_ff    <= {1'b0, arr_ff[CAP_W-1:1]};
               // shift the new capture in behind the old one
               prev_ff   <= {n_b, prev_ff[CAP_W-1:1]};
               if (step_ff == STEP_W'(CAP_W - 1)) begin
                  per_ff   <= (!borrow_in && nz_in) ? diff_shift : wrap_shift;
                  phase_ff <= PH_STAT;
                  step_ff  <= '0;
                  lt_ff    <= 1'b0;
                  gt_ff    <= 1'b0;
                  sc_ff    <= 1'b0;
               end else begin
                  per_ff  <= diff_shift;
                  step_ff <= step_ff + 1'b1;
               end
            end
            PH_STAT: begin
               sum_ff <= {s_b, sum_ff[SUM_W-1:1]};
               sc_ff  <= sc_in;
               lt_ff  <= lt_in;
               gt_ff  <= gt_in;
               if (in_range) begin
                  per_ff <= {per_ff[0], per_ff[CAP_W-1:1]};
                  min_ff <= {min_ff[0], min_ff[CAP_W-1:1]};
                  max_ff <= {max_ff[0], max_ff[CAP_W-1:1]};
               end
               if (step_ff == STEP_W'(SUM_W - 1)) begin
                  if (seed_ff || lt_ff) min_ff <= per_ff;
                  if (seed_ff || gt_ff) max_ff <= per_ff;
                  phase_ff <= PH_IDLE;
                  done_ff  <= 1'b1;
               end else begin
                  step_ff <= step_ff + 1'b1;
               end
            end
            default: phase_ff <= PH_IDLE;
         endcase
      end
   end

   assign status.busy = phase_ff != PH_IDLE;
   assign status.done = done_ff;
   assign shortest    = min_ff;
   assign longest     = max_ff;
   assign period_sum  = sum_ff;

endmodule

// ===== hdl/icfm_divider.sv =====
// Shared restoring divider, one quotient bit per cycle.
// Depends on icfm_pkg.
module icfm_divider
   import icfm_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SUM_W-1:0]  dividend,
   input  logic [CAP_W-1:0]  divisor,
   output unit_status_type   status,
   output logic [SUM_W-1:0]  quotient
);

   logic              busy_ff, done_ff;
   logic [STEP_W-1:0] step_ff;
   logic [SUM_W-1:0]  dvd_ff;
   logic [CAP_W-1:0]  dsr_ff, rem_ff;
   logic [CAP_W:0]    trial, diff;
   logic              ge;

   always_comb begin
      trial = {rem_ff, dvd_ff[SUM_W-1]};
      ge    = trial >= {1'b0, dsr_ff};
      diff  = trial - {1'b0, dsr_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (!busy_ff) begin
            if (start) begin
               busy_ff <= 1'b1;
               step_ff <= '0;
               dvd_ff  <= dividend;
               dsr_ff  <= divisor;
               rem_ff  <= '0;
            end
         end else begin
            // quotient bits shift in where dividend bits leave
            dvd_ff <= {dvd_ff[SUM_W-2:0], ge};
            rem_ff <= ge ? diff[CAP_W-1:0] : trial[CAP_W-1:0];
            if (step_ff == STEP_W'(SUM_W - 1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff + 1'b1;
            end
         end
      end
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quotient    = dvd_ff;

endmodule

// ===== hdl/input_capture_frequency_meter.sv =====
// Input capture frequency meter. The first capture of a window is stored as the reference; every
// further capture runs the serial period difference and wrap, then the serial min, max and
// 36-bit sum update. The last capture of a window adds four passes of the one shared serial
// divider (average period, then the three frequencies) before the result item is offered.
// A result waiting on rsp_stall blocks a new window end only, not the captures in between.
module input_capture_frequency_meter
   import icfm_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CAP_W-1:0]       csr_write_data,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [CAP_W-1:0]       req_capture_value,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [CAP_W-1:0]       rsp_max_freq_hz,
   output logic [CAP_W-1:0]       rsp_min_freq_hz,
   output logic [CAP_W-1:0]       rsp_avg_freq_hz,
   output logic                   rsp_result_valid
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_ACC  = 3'd1;
   localparam logic [2:0] ST_DAVG = 3'd2;
   localparam logic [2:0] ST_DMAX = 3'd3;
   localparam logic [2:0] ST_DMIN = 3'd4;
   localparam logic [2:0] ST_DFRQ = 3'd5;
   localparam logic [2:0] ST_LOAD = 3'd6;

   logic [2:0]         state_ff;
   logic [COUNT_W-1:0] count_ff;
   logic               last_ff;
   logic [CAP_W-1:0]   timer_clock_ff, auto_reload_ff;
   logic [CAP_W-1:0]   avg_ff, maxf_ff, minf_ff, avgf_ff;
   logic               rsp_valid_ff, ok_ff;
   logic [CAP_W-1:0]   rsp_max_ff, rsp_min_ff, rsp_avg_ff;

   acc_cmd_type        acc_cmd;
   unit_status_type    acc_status, div_status;
   logic [CAP_W-1:0]   shortest, longest;
   logic [SUM_W-1:0]   period_sum, quotient, div_dividend;
   logic [CAP_W-1:0]   div_divisor;
   logic               div_start, accept, is_last, out_free, all_nonzero;

   assign req_stall = (state_ff != ST_IDLE) || acc_status.busy;
   assign accept    = req_valid && !req_stall;
   assign is_last   = count_ff == COUNT_W'(WINDOW_CAPTURES - 1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign acc_cmd.start = accept;
   assign acc_cmd.first = count_ff == '0;
   assign acc_cmd.seed  = count_ff == COUNT_W'(1);

   always_comb begin
      div_start    = 1'b0;
      div_dividend = {{(SUM_W-CAP_W){1'b0}}, timer_clock_ff};
      div_divisor  = '0;
      case (state_ff)
         ST_ACC: begin
            div_start    = acc_status.done && last_ff;
            div_dividend = period_sum;
            div_divisor  = CAP_W'(AVG_DIVISOR);
         end
         ST_DAVG: begin
            div_start   = div_status.done;
            div_divisor = shortest;
         end
         ST_DMAX: begin
            div_start   = div_status.done;
            div_divisor = longest;
         end
         ST_DMIN: begin
            div_start   = div_status.done;
            div_divisor = avg_ff;
         end
         default: begin
            div_start = 1'b0;
         end
      endcase
   end

   assign all_nonzero = (shortest != '0) && (longest != '0) && (avg_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         timer_clock_ff <= '0;
         auto_reload_ff <= AUTO_RELOAD_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMER_CLOCK: timer_clock_ff <= csr_write_data;
            CSR_AUTO_RELOAD: auto_reload_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         last_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // the load state owns the output register while it is there
         if (rsp_valid_ff && !rsp_stall && state_ff != ST_LOAD) rsp_valid_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  if (count_ff == '0) begin
                     count_ff <= COUNT_W'(1);
                  end else begin
                     count_ff <= is_last ? '0 : count_ff + 1'b1;
                     last_ff  <= is_last;
                     state_ff <= ST_ACC;
                  end
               end
            end
            ST_ACC: begin
               if (acc_status.done) state_ff <= last_ff ? ST_DAVG : ST_IDLE;
            end
            ST_DAVG: begin
               if (div_status.done) begin
                  avg_ff   <= quotient[CAP_W-1:0];
                  state_ff <= ST_DMAX;
               end
            end
            ST_DMAX: begin
               if (div_status.done) begin
                  maxf_ff  <= quotient[CAP_W-1:0];
                  state_ff <= ST_DMIN;
               end
            end
            ST_DMIN: begin
               if (div_status.done) begin
                  minf_ff  <= quotient[CAP_W-1:0];
                  state_ff <= ST_DFRQ;
               end
            end
            ST_DFRQ: begin
               if (div_status.done) begin
                  avgf_ff  <= quotient[CAP_W-1:0];
                  state_ff <= ST_LOAD;
               end
            end
            ST_LOAD: begin
               // hold until the output register is free
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  ok_ff        <= all_nonzero;
                  rsp_max_ff   <= all_nonzero ? maxf_ff : '0;
                  rsp_min_ff   <= all_nonzero ? minf_ff : '0;
                  rsp_avg_ff   <= all_nonzero ? avgf_ff : '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   icfm_accum u_accum (
      .clock       (clock),
      .reset       (reset),
      .cmd         (acc_cmd),
      .capture     (req_capture_value),
      .auto_reload (auto_reload_ff),
      .status      (acc_status),
      .shortest    (shortest),
      .longest     (longest),
      .period_sum  (period_sum)
   );

   icfm_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .status   (div_status),
      .quotient (quotient)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_max_freq_hz  = rsp_max_ff;
   assign rsp_min_freq_hz  = rsp_min_ff;
   assign rsp_avg_freq_hz  = rsp_avg_ff;
   assign rsp_result_valid = ok_ff;

   a_units_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(acc_status.busy && div_status.busy))
      else $error("period unit and divider busy together");

   a_count_in_window: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(WINDOW_CAPTURES - 1))
      else $error("capture count beyond window");

   a_rsp_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_LOAD)
      else $error("result item raised outside load");

   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_status.done |-> (state_ff == ST_DAVG || state_ff == ST_DMAX ||
                           state_ff == ST_DMIN || state_ff == ST_DFRQ))
      else $error("divider finished with no division pending");

endmodule

// ===== sim/tb_input_capture_frequency_meter.sv =====
// Self-checking testbench for the input capture frequency meter.
// Needs icfm_pkg and input_capture_frequency_meter from the hdl folder.
`timescale 1ns / 1ps

module tb_input_capture_frequency_meter;
   import icfm_pkg::*;

   localparam int SETTLE_CYCLES = 300;
   localparam int RANDOM_PHASES = 12;

   typedef struct packed {
      logic [CAP_W-1:0] max_freq;
      logic [CAP_W-1:0] min_freq;
      logic [CAP_W-1:0] avg_freq;
      logic             all_nonzero;
   } window_result_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CAP_W-1:0]       csr_write_data;
   logic                   req_valid;
   logic                   req_stall;
   logic [CAP_W-1:0]       req_capture_value;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic [CAP_W-1:0]       rsp_max_freq_hz;
   logic [CAP_W-1:0]       rsp_min_freq_hz;
   logic [CAP_W-1:0]       rsp_avg_freq_hz;
   logic                   rsp_result_valid;

   // Meter model: registers and window state
   logic [CAP_W-1:0] timer_clock_reg;
   logic [CAP_W-1:0] auto_reload_reg;
   logic [CAP_W-1:0] last_capture;
   logic [CAP_W-1:0] shortest;
   logic [CAP_W-1:0] longest;
   logic [SUM_W-1:0] period_total;
   int unsigned      captures_in_window;

   window_result_type pending_windows[$];
   logic [CAP_W:0]   counter_sim;
   bit               no_gaps;
   int unsigned      error_count;
   int unsigned      captures_sent;
   int unsigned      windows_checked;
   int unsigned      invalid_windows;

   input_capture_frequency_meter DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_capture_value (req_capture_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_max_freq_hz   (rsp_max_freq_hz),
      .rsp_min_freq_hz   (rsp_min_freq_hz),
      .rsp_avg_freq_hz   (rsp_avg_freq_hz),
      .rsp_result_valid  (rsp_result_valid)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("Timeout at %0t with %0d windows still pending", $time, pending_windows.size());
      $display("Regression FAIL");
      $finish;
   end

   // Fold one accepted capture into the window; queue a result when the window closes
   function automatic void account_capture(logic [CAP_W-1:0] cap);
      logic [CAP_W-1:0]  period;
      logic [SUM_W-1:0]  avg_wide;
      logic [CAP_W-1:0]  avg;
      window_result_type res;
      if (captures_in_window == 0) begin
         last_capture       = cap;
         captures_in_window = 1;
         shortest           = '0;
         longest            = '0;
         period_total       = '0;
         return;
      end
      // not greater means the counter wrapped at auto-reload; modulo 2^32
      period = (cap > last_capture) ? cap - last_capture
                                    : auto_reload_reg - last_capture + cap + 32'd1;
      if (captures_in_window == 1 || period > longest) longest = period;
      if (captures_in_window == 1 || period < shortest) shortest = period;
      period_total = period_total + {{(SUM_W-CAP_W){1'b0}}, period};
      last_capture = cap;
      if (captures_in_window + 1 < WINDOW_CAPTURES) begin
         captures_in_window++;
         return;
      end
      captures_in_window = 0;
      avg_wide = period_total / SUM_W'(AVG_DIVISOR);
      avg      = avg_wide[CAP_W-1:0];
      if (shortest != 0 && longest != 0 && avg != 0) begin
         res.max_freq    = timer_clock_reg / shortest;
         res.min_freq    = timer_clock_reg / longest;
         res.avg_freq    = timer_clock_reg / avg;
         res.all_nonzero = 1'b1;
      end else begin
         res = '0;
      end
      pending_windows.push_back(res);
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (no_gaps || r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 15);
      return $urandom_range(40, 150);
   endfunction

   // Counter-like capture stream with random spacing, plus some noise
   function automatic logic [CAP_W-1:0] next_capture();
      logic [CAP_W:0] modulus;
      logic [CAP_W:0] step;
      int unsigned    r;
      modulus = {1'b0, auto_reload_reg} + 33'd1;
      r = $urandom_range(0, 99);
      if (r < 8) return $urandom;
      if (r < 12) step = '0;
      else if (r < 60) step = (CAP_W+1)'($urandom_range(1, 64));
      else if (r < 85) step = (CAP_W+1)'($urandom_range(1, (auto_reload_reg >> 12) + 1));
      else step = (CAP_W+1)'($urandom_range(0, auto_reload_reg));
      counter_sim = (counter_sim + step) % modulus;
      return counter_sim[CAP_W-1:0];
   endfunction

   // Called at a falling edge; returns at a falling edge with valid still high
   task automatic send_capture(input logic [CAP_W-1:0] cap);
      int unsigned gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_capture_value = cap;
      do @(posedge clock); while (req_stall);
      account_capture(cap);
      captures_sent++;
      @(negedge clock);
   endtask

   // Drop valid, wait for every queued result, then let the block settle
   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending_windows.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CAP_W-1:0] data);
      csr_write_enable = 1'b1;
      csr_index        = idx;
      csr_write_data   = data;
      @(negedge clock);
      csr_write_enable = 1'b0;
      if (idx == CSR_TIMER_CLOCK) timer_clock_reg = data;
      else if (idx == CSR_AUTO_RELOAD) auto_reload_reg = data;
   endtask

   task automatic report_field(input string name, input logic [CAP_W-1:0] expected,
                               input logic [CAP_W-1:0] actual);
      if (actual !== expected) begin
         $display("%0t mismatch %s: expected %0h, got %0h", $time, name, expected, actual);
         error_count++;
      end
   endtask

   // Reset register values; one period wraps to zero modulo 2^32, another at 65535
   task automatic test_wrapped_zero_period();
      logic [CAP_W-1:0] caps [WINDOW_CAPTURES];
      caps = '{32'h0001_0000, 32'h0, 32'd100, 32'd65535, 32'd5,
               32'hFFFF_FFFF, 32'd7, 32'd1000, 32'd2000, 32'd2000};
      foreach (caps[i]) send_capture(caps[i]);
      wait_drained();
   endtask

   // Full-scale registers; every period is 2^32-1 so the sum needs all 36 bits
   task automatic test_longest_periods();
      write_register(CSR_TIMER_CLOCK, 32'hFFFF_FFFF);
      write_register(CSR_AUTO_RELOAD, 32'hFFFF_FFFF);
      for (int i = WINDOW_CAPTURES - 1; i >= 0; i--) send_capture(i);
      wait_drained();
   endtask

   // Extreme, then random register settings; phase boundaries fall anywhere inside a window
   task automatic test_random_windows();
      logic [CAP_W-1:0] clk_hz;
      logic [CAP_W-1:0] reload;
      int unsigned      n_items;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: begin clk_hz = 32'hFFFF_FFFF; reload = 32'h0; end
            1: begin clk_hz = 32'h0; reload = 32'hFFFF_FFFF; end
            default: begin
               case ($urandom_range(0, 3))
                  0: clk_hz = 32'h0;
                  1: clk_hz = 32'hFFFF_FFFF;
                  default: clk_hz = $urandom;
               endcase
               case ($urandom_range(0, 5))
                  0: reload = 32'h0;
                  1: reload = 32'hFFFF_FFFF;
                  2: reload = AUTO_RELOAD_RESET;
                  3: reload = $urandom_range(1, 255);
                  default: reload = $urandom;
               endcase
            end
         endcase
         write_register(CSR_TIMER_CLOCK, clk_hz);
         write_register(CSR_AUTO_RELOAD, reload);
         no_gaps = (phase % 4 == 3);
         n_items = $urandom_range(100, 125);
         repeat (n_items) send_capture(next_capture());
         wait_drained();
      end
      no_gaps = 1'b0;
   endtask

   // Result sink: random back-pressure, mostly short stalls, a few long ones
   initial begin
      int unsigned stall_left;
      int unsigned r;
      stall_left = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_stall = 1'b1;
            stall_left--;
         end else begin
            rsp_stall = 1'b0;
            r = $urandom_range(0, 99);
            if (!no_gaps && r < 20) stall_left = $urandom_range(1, 3);
            else if (!no_gaps && r < 23) stall_left = $urandom_range(30, 150);
         end
      end
   end

   always @(posedge clock) begin
      window_result_type exp_res;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_windows.size() == 0) begin
            $display("%0t unexpected result item: max %0h min %0h avg %0h valid %0b", $time,
                     rsp_max_freq_hz, rsp_min_freq_hz, rsp_avg_freq_hz, rsp_result_valid);
            error_count++;
         end else begin
            exp_res = pending_windows.pop_front();
            report_field("max_freq_hz", exp_res.max_freq, rsp_max_freq_hz);
            report_field("min_freq_hz", exp_res.min_freq, rsp_min_freq_hz);
            report_field("avg_freq_hz", exp_res.avg_freq, rsp_avg_freq_hz);
            report_field("result_valid", CAP_W'(exp_res.all_nonzero),
                         CAP_W'(rsp_result_valid));
            windows_checked++;
            if (!exp_res.all_nonzero) invalid_windows++;
         end
      end
   end

   initial begin
      reset              = 1'b1;
      csr_write_enable   = 1'b0;
      csr_index          = CSR_TIMER_CLOCK;
      csr_write_data     = '0;
      req_valid          = 1'b0;
      req_capture_value  = '0;
      no_gaps            = 1'b0;
      error_count        = 0;
      captures_sent      = 0;
      windows_checked    = 0;
      invalid_windows    = 0;
      counter_sim        = '0;
      timer_clock_reg    = '0;
      auto_reload_reg    = AUTO_RELOAD_RESET;
      last_capture       = '0;
      shortest           = '0;
      longest            = '0;
      period_total       = '0;
      captures_in_window = 0;
      repeat (8) @(negedge clock);
      reset = 1'b0;

      test_wrapped_zero_period();
      test_longest_periods();
      test_random_windows();
      wait_drained();

      $display("Sent %0d captures; checked %0d windows, %0d of them with a zero period.",
               captures_sent, windows_checked, invalid_windows);
      $display("Register extremes and random settings applied across %0d random phases.",
               RANDOM_PHASES);
      if (error_count == 0 && pending_windows.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("%0d mismatches, %0d windows left unmatched", error_count,
                  pending_windows.size());
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
